// ===== rtl/tdpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime test package
// Shared widths, defaults, seed primes and the remainder unit status type.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF  = 8192;
  localparam int unsigned NUMBER_WIDTH_DEF = 31;

  // Stored primes are 16 bits; candidates and trial divisors need one more.
  localparam int unsigned PRIME_W    = 16;
  localparam int unsigned CAND_W     = 17;
  localparam int unsigned SQ_W       = 2 * CAND_W;
  localparam int unsigned SEED_COUNT = 10;

  localparam logic [CAND_W-1:0] STORE_LIMIT     = 17'd65535;
  localparam logic [CAND_W-1:0] FIRST_CANDIDATE = 17'd31;

  // Status of the remainder unit as seen by the sequencer.
  typedef struct packed {
    logic done;
    logic rem_zero;
  } tdpt_div_sts_t;

  // The first ten primes, which occupy table entries 0 to 9 from reset on.
  function automatic logic [PRIME_W-1:0] seed_prime(input logic [3:0] idx);
    logic [PRIME_W-1:0] p;
    case (idx)
      4'd0:    p = 16'd2;
      4'd1:    p = 16'd3;
      4'd2:    p = 16'd5;
      4'd3:    p = 16'd7;
      4'd4:    p = 16'd11;
      4'd5:    p = 16'd13;
      4'd6:    p = 16'd17;
      4'd7:    p = 16'd19;
      4'd8:    p = 16'd23;
      4'd9:    p = 16'd29;
      default: p = 16'd0;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/tdpt_num_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Number channel
// Valid/ready channel that carries one number to be tested.
// ----------------------------------------------------------------------------
interface tdpt_num_if #(
  parameter int unsigned Width = 31
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

// ===== rtl/tdpt_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries the prime verdict for one number.
// ----------------------------------------------------------------------------
interface tdpt_res_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

// ===== rtl/tdpt_rem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring division, one dividend bit per cycle, reports a zero remainder.
// ----------------------------------------------------------------------------
module tdpt_rem #(
  parameter int unsigned DividendWidth = 31
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [DividendWidth-1:0]     dividend_i,
  input  logic [tdpt_pkg::CAND_W-1:0]  divisor_i,
  output tdpt_pkg::tdpt_div_sts_t      sts_o
);
  import tdpt_pkg::*;

  localparam int unsigned CntW = $clog2(DividendWidth + 1);

  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [DividendWidth-1:0] dvd_q, dvd_d;
  logic [CAND_W-1:0]        dvs_q, dvs_d;
  logic [CAND_W-1:0]        rem_q, rem_d;
  logic [CAND_W:0]          trial;

  assign trial = {rem_q, dvd_q[DividendWidth-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DividendWidth);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = CAND_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[CAND_W-1:0];
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign sts_o.done     = done_q;
  assign sts_o.rem_zero = (rem_q == '0);

endmodule

// ===== rtl/trial_division_prime_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime test
// Tests each number for primality against a growing table of small primes.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload             Transfer
//  --------  ---------  ------------------  ---------------------
//  num_i     in         number              valid && ready
//  res_o     out        is_prime            valid && ready
//
// One item is worked on at a time; num_i.ready is high only while idle.
// A number below 2 skips the table: its result is registered in S_FIN once
// the output register is free, and the block is ready again in the same
// cycle as that result becomes valid. Every table prime tried costs a table
// read, a squaring, a compare and a restoring division of one bit per cycle
// over max(NumberWidth, 17) bits, so the remainder unit sets the pace.
// Extending the table repeats that per candidate against the stored primes.
// After reset the block is ready at once: no memory clearing pass is needed,
// since the ten seed primes come from a constant table. A stalled result is
// held in its output register until taken.
//
// The number is divided by the stored primes in ascending order while the
// prime squared does not exceed it. When the table runs out first, odd
// candidates from next_cand_q on are tried as divisors. While the table has
// room and the candidate fits in 16 bits, each candidate is itself tested
// against the table first and appended when prime, so the table always
// holds every prime below next_cand_q.
// ----------------------------------------------------------------------------
module trial_division_prime_test #(
  parameter int unsigned TableDepth  = tdpt_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned NumberWidth = tdpt_pkg::NUMBER_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tdpt_num_if.sink     num_i,
  tdpt_res_if.source   res_o
);
  import tdpt_pkg::*;

  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam int unsigned DivW = (NumberWidth > CAND_W) ? NumberWidth : CAND_W;

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RD     = 4'd1;  // table read issued
  localparam logic [3:0] S_SQ     = 4'd2;  // square the table prime
  localparam logic [3:0] S_CMP    = 4'd3;  // square bound or start division
  localparam logic [3:0] S_DIV    = 4'd4;  // divide by table prime
  localparam logic [3:0] S_C_SQ   = 4'd5;  // square the odd candidate
  localparam logic [3:0] S_C_CMP  = 4'd6;  // bound, grow table or divide
  localparam logic [3:0] S_APPEND = 4'd7;  // store a new prime
  localparam logic [3:0] S_N_DIV  = 4'd8;  // divide number by candidate
  localparam logic [3:0] S_FIN    = 4'd9;  // hand verdict to output

  logic [3:0]             state_q, state_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [CAND_W-1:0]      next_cand_q, next_cand_d;
  logic                   cand_mode_q, cand_mode_d;
  logic                   growing_q, growing_d;
  logic                   cand_prime_q, cand_prime_d;
  logic                   res_valid_q, res_valid_d;

  logic [NumberWidth-1:0] n_q, n_d;
  logic [CAND_W-1:0]      c_q, c_d;
  logic [CntW-1:0]        idx_q, idx_d;
  logic [SQ_W-1:0]        sq_q, sq_d;
  logic [CAND_W-1:0]      dvs_q, dvs_d;
  logic                   res_bit_q, res_bit_d;
  logic                   res_q, res_d;

  // Prime table. Entries below SEED_COUNT are never written; reads of them
  // are served from the seed constants instead.
  logic [PRIME_W-1:0]     mem [TableDepth];
  logic [PRIME_W-1:0]     mem_rd_q;
  logic [PRIME_W-1:0]     seed_q;
  logic                   seed_hit_q;
  logic                   mem_we;

  logic [CAND_W-1:0]      p_val;
  logic [CAND_W-1:0]      mul_a;
  logic [SQ_W-1:0]        n_ext;
  logic [SQ_W-1:0]        target;
  logic [CntW-1:0]        idx_nx;

  logic                   div_start;
  logic [DivW-1:0]        div_dividend;
  logic [CAND_W-1:0]      div_divisor;
  tdpt_div_sts_t          div_sts;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[IdxW-1:0]] <= c_q[PRIME_W-1:0];
    end
    if (state_q == S_RD) begin
      mem_rd_q   <= mem[idx_q[IdxW-1:0]];
      seed_q     <= seed_prime(idx_q[3:0]);
      seed_hit_q <= (idx_q < CntW'(SEED_COUNT));
    end
  end

  assign p_val  = {1'b0, (seed_hit_q ? seed_q : mem_rd_q)};
  assign mul_a  = (state_q == S_C_SQ) ? c_q : p_val;
  assign n_ext  = SQ_W'(n_q);
  // In candidate mode the bound is the candidate itself, else the number.
  assign target = cand_mode_q ? SQ_W'(c_q) : n_ext;
  assign idx_nx = idx_q + 1'b1;

  assign div_dividend = (state_q == S_CMP && cand_mode_q) ? DivW'(c_q) : DivW'(n_q);
  assign div_divisor  = (state_q == S_CMP) ? dvs_q : c_q;

  tdpt_rem #(
    .DividendWidth (DivW)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .sts_o      (div_sts)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    next_cand_d  = next_cand_q;
    cand_mode_d  = cand_mode_q;
    growing_d    = growing_q;
    cand_prime_d = cand_prime_q;
    n_d          = n_q;
    c_d          = c_q;
    idx_d        = idx_q;
    sq_d         = sq_q;
    dvs_d        = dvs_q;
    res_bit_d    = res_bit_q;
    res_d        = res_q;
    res_valid_d  = res_valid_q && !res_o.ready;
    mem_we       = 1'b0;
    div_start    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (num_i.valid) begin
          n_d = num_i.number;
          if (num_i.number < NumberWidth'(2)) begin
            res_bit_d = 1'b0;
            state_d   = S_FIN;
          end else begin
            cand_mode_d = 1'b0;
            idx_d       = '0;
            state_d     = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = S_SQ;
      end
      S_SQ: begin
        sq_d    = mul_a * mul_a;
        dvs_d   = p_val;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (sq_q > target) begin
          if (cand_mode_q) begin
            cand_prime_d = 1'b1;
            state_d      = S_APPEND;
          end else begin
            res_bit_d = 1'b1;
            state_d   = S_FIN;
          end
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_sts.done) begin
          if (div_sts.rem_zero) begin
            if (cand_mode_q) begin
              cand_prime_d = 1'b0;
              state_d      = S_APPEND;
            end else begin
              res_bit_d = 1'b0;
              state_d   = S_FIN;
            end
          end else if (idx_nx < count_q) begin
            idx_d   = idx_nx;
            state_d = S_RD;
          end else if (cand_mode_q) begin
            cand_prime_d = 1'b1;
            state_d      = S_APPEND;
          end else begin
            // Table exhausted: carry on with odd candidates.
            c_d       = next_cand_q;
            growing_d = 1'b1;
            state_d   = S_C_SQ;
          end
        end
      end
      S_C_SQ: begin
        sq_d    = mul_a * mul_a;
        state_d = S_C_CMP;
      end
      S_C_CMP: begin
        if (sq_q > n_ext) begin
          res_bit_d = 1'b1;
          state_d   = S_FIN;
        end else if (growing_q && count_q < CntW'(TableDepth) && c_q <= STORE_LIMIT) begin
          cand_mode_d = 1'b1;
          idx_d       = '0;
          state_d     = S_RD;
        end else begin
          // Once growth stops it stays off for the rest of this item.
          growing_d = 1'b0;
          div_start = 1'b1;
          state_d   = S_N_DIV;
        end
      end
      S_APPEND: begin
        if (cand_prime_q) begin
          mem_we  = 1'b1;
          count_d = count_q + 1'b1;
        end
        next_cand_d = c_q + CAND_W'(2);
        cand_mode_d = 1'b0;
        div_start   = 1'b1;
        state_d     = S_N_DIV;
      end
      S_N_DIV: begin
        if (div_sts.done) begin
          if (div_sts.rem_zero) begin
            res_bit_d = 1'b0;
            state_d   = S_FIN;
          end else begin
            c_d     = c_q + CAND_W'(2);
            state_d = S_C_SQ;
          end
        end
      end
      S_FIN: begin
        if (!res_valid_q || res_o.ready) begin
          res_valid_d = 1'b1;
          res_d       = res_bit_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= CntW'(SEED_COUNT);
      next_cand_q  <= FIRST_CANDIDATE;
      cand_mode_q  <= 1'b0;
      growing_q    <= 1'b0;
      cand_prime_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      next_cand_q  <= next_cand_d;
      cand_mode_q  <= cand_mode_d;
      growing_q    <= growing_d;
      cand_prime_q <= cand_prime_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    c_q       <= c_d;
    idx_q     <= idx_d;
    sq_q      <= sq_d;
    dvs_q     <= dvs_d;
    res_bit_q <= res_bit_d;
    res_q     <= res_d;
  end

  assign num_i.ready    = (state_q == S_IDLE);
  assign res_o.valid    = res_valid_q;
  assign res_o.is_prime = res_q;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime test bench
// Feeds numbers into the prime tester over its valid/ready channel and checks
// every verdict against a behavioral model of the growing prime table. The
// model runs in step with the accepted numbers, so each verdict is known when
// its number is taken. A directed group covers the small numbers, the seed
// table edges, table growth, the full table and the largest input. A random
// group follows. Both channel sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import tdpt_pkg::*;

  localparam int unsigned NUM_W = NUMBER_WIDTH_DEF;

  // The table is kept shallow on purpose. With 64 entries it fills once the
  // prime 311 is stored, which a number near 10^5 already causes. The path
  // where odd divisors beyond the table are tried one by one is then taken
  // by most of the larger numbers. With the default depth that path could
  // not be reached with any 31-bit number.
  localparam int unsigned TAB_DEPTH = 64;

  localparam int unsigned RAND_ITEMS = 80;
  localparam int unsigned IDLE_PCT   = 15;
  localparam int unsigned TAIL_CYCLES = 200;

  // Random large numbers are kept cheap. Their smallest factor must be no
  // larger than this, or they are made even.
  localparam longint unsigned FACTOR_CAP = 499;

  // The slowest item is the largest prime, 2^31 - 1. It tries about 23000
  // divisors beyond the table, one restoring division each. The limit is
  // set to cover that item and the rest of the run.
  localparam longint unsigned CYCLE_LIMIT = 12_000_000;

  typedef struct {
    logic [NUM_W-1:0] number;
    bit               drain;    // hold this item back until nothing is outstanding
  } num_item_t;

  typedef struct {
    logic [NUM_W-1:0] number;
    bit               is_prime;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  tdpt_num_if #(.Width(NUM_W)) num_ch ();
  tdpt_res_if                  res_ch ();

  trial_division_prime_test #(
    .TableDepth  (TAB_DEPTH),
    .NumberWidth (NUM_W)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .num_i  (num_ch),
    .res_o  (res_ch)
  );

  num_item_t       pending_q[$];   // numbers still to be offered
  verdict_t        verdict_q[$];   // verdicts owed by the block, oldest first
  int unsigned     taken_cnt;      // numbers accepted by the block
  int unsigned     checked_cnt;    // verdicts received and checked
  int unsigned     error_cnt = 0;
  longint unsigned cycle_cnt = 0;

  // Model state: the table of known primes, how many entries are valid, and
  // the next odd value to try as a new entry.
  logic [PRIME_W-1:0] prime_tab [TAB_DEPTH];
  int unsigned        prime_cnt;
  logic [CAND_W-1:0]  next_cand;

  // Smallest divisor d of n with d <= cap and d*d <= n, or 0 when none exists.
  function automatic longint unsigned smallest_factor(longint unsigned n,
                                                      longint unsigned cap);
    longint unsigned d;
    d = 2;
    while (d <= cap && d * d <= n) begin
      if (n % d == 0) return d;
      d = (d == 2) ? 3 : d + 2;
    end
    return 0;
  endfunction

  // Works out the verdict for one accepted number and advances the table
  // the same way the block does.
  function automatic bit judge_number(logic [NUM_W-1:0] number);
    longint unsigned n;
    longint unsigned p;
    longint unsigned c;
    bit              growing;
    bit              cand_prime;
    n = number;
    if (n < 2) return 1'b0;

    // Stored primes in ascending order, while p*p does not exceed n.
    for (int i = 0; i < prime_cnt; i++) begin
      p = prime_tab[i];
      if (p * p > n) return 1'b1;
      if (n % p == 0) return 1'b0;
    end

    // The table ran out first. Continue with odd candidates. While there is
    // room and the candidate fits in 16 bits, test it against the table and
    // store it when it is prime.
    c       = next_cand;
    growing = 1'b1;
    while (c * c <= n) begin
      if (growing) begin
        if (prime_cnt < TAB_DEPTH && c <= STORE_LIMIT) begin
          cand_prime = 1'b1;
          for (int j = 0; j < prime_cnt; j++) begin
            p = prime_tab[j];
            if (p * p > c) break;
            if (c % p == 0) begin
              cand_prime = 1'b0;
              break;
            end
          end
          if (cand_prime) begin
            prime_tab[prime_cnt] = c[PRIME_W-1:0];
            prime_cnt++;
          end
          next_cand = CAND_W'(c + 2);
        end else begin
          growing = 1'b0;
        end
      end
      if (n % c == 0) return 1'b0;
      c += 2;
    end
    return 1'b1;
  endfunction

  // Random stall decision for one side of a channel. No stall is drawn
  // while cnt is inside [lo, hi), which gives one long stretch at full rate.
  function automatic bit idle_now(int unsigned cnt, int unsigned lo, int unsigned hi);
    if (cnt >= lo && cnt < hi) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  task automatic add_number(logic [NUM_W-1:0] number, bit drain);
    num_item_t item;
    item.number = number;
    item.drain  = drain;
    pending_q.push_back(item);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle budget. Running past it means the block hung or is far too slow.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Driver: offers the next pending number when the channel slot is free and no
  // random stall is drawn. An offered number stays on the channel until taken.
  // Numbers marked for draining wait until every verdict owed so far has arrived.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_ch.valid  <= 1'b0;
      num_ch.number <= '0;
    end else if (!num_ch.valid || num_ch.ready) begin
      if (pending_q.size() != 0 && !idle_now(taken_cnt, 40, 60) &&
          (!pending_q[0].drain || (!num_ch.valid && taken_cnt == checked_cnt))) begin
        num_ch.valid  <= 1'b1;
        num_ch.number <= pending_q[0].number;
        void'(pending_q.pop_front());
      end else begin
        num_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: drives the result ready with random stalls. It checks each
  // verdict taken against the oldest one owed. It then records the verdict
  // for any number taken at this edge. The check comes first, so a number
  // taken at this edge can never be matched to a verdict at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      taken_cnt    <= 0;
      checked_cnt  <= 0;
    end else begin
      res_ch.ready <= !idle_now(checked_cnt, 55, 75);
      if (res_ch.valid && res_ch.ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected verdict is_prime=%b with no number outstanding",
                   $time, res_ch.is_prime);
          error_cnt++;
        end else begin
          if (res_ch.is_prime !== verdict_q[0].is_prime) begin
            $display("%0t: number %0d expected is_prime=%b actual is_prime=%b",
                     $time, verdict_q[0].number, verdict_q[0].is_prime,
                     res_ch.is_prime);
            error_cnt++;
          end
          void'(verdict_q.pop_front());
          checked_cnt <= checked_cnt + 1;
        end
      end
      if (num_ch.valid && num_ch.ready) begin
        verdict_t v;
        v.number   = num_ch.number;
        v.is_prime = judge_number(num_ch.number);
        verdict_q.push_back(v);
        taken_cnt <= taken_cnt + 1;
      end
    end
  end

  initial begin
    logic [31:0]      raw;
    logic [NUM_W-1:0] n;
    int unsigned      pick;

    // Every block input is known from time zero, before the reset is seen.
    rst_ni        = 1'b0;
    num_ch.valid  = 1'b0;
    num_ch.number = '0;
    res_ch.ready  = 1'b0;

    // Model state after reset: the ten seed primes and the first candidate.
    prime_tab[0] = 16'd2;
    prime_tab[1] = 16'd3;
    prime_tab[2] = 16'd5;
    prime_tab[3] = 16'd7;
    prime_tab[4] = 16'd11;
    prime_tab[5] = 16'd13;
    prime_tab[6] = 16'd17;
    prime_tab[7] = 16'd19;
    prime_tab[8] = 16'd23;
    prime_tab[9] = 16'd29;
    for (int i = SEED_COUNT; i < TAB_DEPTH; i++) prime_tab[i] = '0;
    prime_cnt = SEED_COUNT;
    next_cand = FIRST_CANDIDATE;

    // Directed group. 0 and 1 are not prime. 2 and 3 are decided by the
    // first table entries. 29 is the last seed prime. 31 is the first
    // candidate and needs no growth. 841 is the square of the last seed
    // prime. 961 forces the table to grow to 31.
    add_number(0, 1'b0);
    add_number(1, 1'b0);
    add_number(2, 1'b0);
    add_number(3, 1'b0);
    add_number(4, 1'b0);
    add_number(29, 1'b0);
    add_number(31, 1'b0);
    add_number(841, 1'b0);
    add_number(961, 1'b0);
    add_number(997, 1'b0);
    add_number(1024, 1'b0);
    // 65521 grows the table to all primes up to 251. 96721 is 311 squared.
    // It stores exactly up to 311, which fills the 64 entries. 97969 is
    // 313 squared, and only the divisor tried beyond the full table finds
    // that factor.
    add_number(65521, 1'b0);
    add_number(65536, 1'b0);
    add_number(96721, 1'b0);
    add_number(97969, 1'b0);
    add_number(1000003, 1'b0);
    // Wide bit patterns and the top of the input range. The largest value,
    // 2^31 - 1, is prime and by far the slowest item. The block is drained
    // before it is offered.
    add_number(31'h5555_5555, 1'b0);
    add_number(31'h2AAA_AAAA, 1'b0);
    add_number(31'h4000_0000, 1'b0);
    add_number(31'h7FFF_FFFE, 1'b0);
    add_number(31'h7FFF_FFFF, 1'b1);

    // Random group. The mix is small numbers, primes below about 2*10^5 and
    // full-width numbers. The full-width numbers are kept to those with a
    // small factor, or are made even, so that none of them takes long.
    for (int k = 0; k < RAND_ITEMS; k++) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        n = NUM_W'($urandom_range(1023));
      end else if (pick < 60) begin
        n = NUM_W'($urandom_range(200000));
        if (n < 2) n = 2;
        while (smallest_factor(n, n) != 0) n++;
      end else begin
        raw = $urandom();
        n   = raw[NUM_W-1:0];
        if (n >= FACTOR_CAP * FACTOR_CAP && smallest_factor(n, FACTOR_CAP) == 0)
          n[0] = 1'b0;
      end
      add_number(n, k == RAND_ITEMS / 2);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every number has been taken and every verdict has come
    // back. Then give the block time to show any stray result.
    while (pending_q.size() != 0 || num_ch.valid || taken_cnt != checked_cnt)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (error_cnt == 0 && verdict_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
